/* design/parametric_curve_point_generator_defines.svh */
// Assertion macros shared by the curve point generator RTL.
`ifndef PARAMETRIC_CURVE_POINT_GENERATOR_DEFINES_SVH
`define PARAMETRIC_CURVE_POINT_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define PCPG_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error("curve point generator check failed");

// Next-cycle implication, sampled on the block clock, off during reset.
`define PCPG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("curve point generator check failed");

`endif

/* design/pcpg_pkg.sv */
// Shared types and fixed constants of the curve point generator.
`default_nettype none

package pcpg_pkg;

  localparam int unsigned IDX_W    = 8;
  localparam int unsigned CENTER_W = 11;
  localparam int unsigned PIXEL_W  = 13;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;

  // Angles in Q30 radians used when the trig and ramp tables are built.
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
  localparam logic [63:0] Q30_PI      = 64'd3373259426;
  localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;

  typedef enum logic [1:0] {
    SHAPE_ASTROID     = 2'd0,
    SHAPE_CYCLOID     = 2'd1,
    SHAPE_HUYGENS     = 2'd2,
    SHAPE_HYPOCYCLOID = 2'd3
  } shape_e;

  localparam logic [1:0] REG_SHAPE_MODE = 2'd0;
  localparam logic [1:0] REG_CENTER_X   = 2'd1;
  localparam logic [1:0] REG_CENTER_Y   = 2'd2;

  localparam logic [CENTER_W-1:0] CENTER_X_RESET = 11'd200;
  localparam logic [CENTER_W-1:0] CENTER_Y_RESET = 11'd100;

  // Interval length in turns and number of samples per curve.
  localparam int unsigned TURNS_ASTROID     = 1;
  localparam int unsigned STEPS_ASTROID     = 256;
  localparam int unsigned TURNS_CYCLOID     = 3;
  localparam int unsigned STEPS_CYCLOID     = 128;
  localparam int unsigned TURNS_HUYGENS     = 2;
  localparam int unsigned STEPS_HUYGENS     = 256;
  localparam int unsigned TURNS_HYPOCYCLOID = 1;
  localparam int unsigned STEPS_HYPOCYCLOID = 256;

  typedef struct packed {
    logic   valid;
    shape_e mode;
    logic   beyond;
  } ctl_t;

endpackage

`default_nettype wire

/* design/parametric_curve_point_generator.sv */
// Top level of the curve point generator: registers, pipeline and pixel output.
//
//  Channel   Handshake                          Payload
//  config    psel, penable, pwrite, pready      paddr, pwdata, prdata
//  sample    start (taken when busy is low)     sample_index_i
//  point     result_valid_o (one-cycle strobe)  pixel_x_o, pixel_y_o, beyond_end_o
//
// One sample is taken in every cycle; busy never rises.
// Each point passes, after its sample is taken, through the input register, phase,
// table lookup, three shape stages (two of them for the astroid cubes) and the
// output register with the centre offset.
// Reset clears the valid bits of every stage and loads the register reset values.
// The point is shown for one cycle only; nothing inside the pipeline ever waits.
`default_nettype none

`include "parametric_curve_point_generator_defines.svh"

module parametric_curve_point_generator #(
  parameter int unsigned PHASE_STEPS_PER_TURN = 256,
  parameter int unsigned FRACTION_BITS        = 15
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pcpg_pkg::ADDR_W-1:0]         paddr,
  input  logic [pcpg_pkg::DATA_W-1:0]         pwdata,
  output logic [pcpg_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                start,
  output logic                                busy,
  input  logic [pcpg_pkg::IDX_W-1:0]          sample_index_i,
  output logic                                result_valid_o,
  output logic signed [pcpg_pkg::PIXEL_W-1:0] pixel_x_o,
  output logic signed [pcpg_pkg::PIXEL_W-1:0] pixel_y_o,
  output logic                                beyond_end_o
);
  import pcpg_pkg::*;

  localparam int unsigned IW      = $clog2(PHASE_STEPS_PER_TURN);
  localparam int unsigned SW      = FRACTION_BITS + 2;
  localparam int unsigned TW      = FRACTION_BITS + 6;
  localparam int unsigned LATENCY = 7;

  function automatic logic [IDX_W:0] mode_steps(input shape_e m);
    logic [IDX_W:0] r;
    case (m)
      SHAPE_ASTROID: r = (IDX_W+1)'(STEPS_ASTROID);
      SHAPE_CYCLOID: r = (IDX_W+1)'(STEPS_CYCLOID);
      SHAPE_HUYGENS: r = (IDX_W+1)'(STEPS_HUYGENS);
      default:       r = (IDX_W+1)'(STEPS_HYPOCYCLOID);
    endcase
    return r;
  endfunction

  shape_e              shape_mode_q, shape_mode_d;
  logic [CENTER_W-1:0] center_x_q, center_x_d;
  logic [CENTER_W-1:0] center_y_q, center_y_d;
  logic                cfg_write;

  logic                accept;
  ctl_t                in_ctl_q, in_ctl_d;
  logic [IDX_W-1:0]    idx_q;

  ctl_t                ph_ctl;
  logic [IW-1:0]       ph;
  logic [IW-1:0]       phk;
  logic [TW-1:0]       ph_t;
  ctl_t                trig_ctl;
  logic signed [SW-1:0] cos_v;
  logic signed [SW-1:0] sin_v;
  logic signed [SW-1:0] cosk_v;
  logic signed [SW-1:0] sink_v;
  logic [TW-1:0]       trig_t;
  ctl_t                shape_ctl;
  logic signed [PIXEL_W-1:0] off_x;
  logic signed [PIXEL_W-1:0] off_y;

  ctl_t                      out_ctl_q;
  logic signed [PIXEL_W-1:0] pixel_x_q, pixel_x_d;
  logic signed [PIXEL_W-1:0] pixel_y_q, pixel_y_d;

  // Register file.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    shape_mode_d = shape_mode_q;
    center_x_d   = center_x_q;
    center_y_d   = center_y_q;
    if (cfg_write) begin
      unique case (paddr[3:2])
        REG_SHAPE_MODE: shape_mode_d = shape_e'(pwdata[1:0]);
        REG_CENTER_X:   center_x_d   = pwdata[CENTER_W-1:0];
        REG_CENTER_Y:   center_y_d   = pwdata[CENTER_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SHAPE_MODE: prdata = DATA_W'(shape_mode_q);
      REG_CENTER_X:   prdata = DATA_W'(center_x_q);
      REG_CENTER_Y:   prdata = DATA_W'(center_y_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_mode_q <= SHAPE_ASTROID;
      center_x_q   <= CENTER_X_RESET;
      center_y_q   <= CENTER_Y_RESET;
    end else begin
      shape_mode_q <= shape_mode_d;
      center_x_q   <= center_x_d;
      center_y_q   <= center_y_d;
    end
  end

  // Input register; the end-of-interval flag is settled right here.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    in_ctl_d.valid  = accept;
    in_ctl_d.mode   = shape_mode_q;
    in_ctl_d.beyond = {1'b0, sample_index_i} >= mode_steps(shape_mode_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ctl_q <= '0;
    end else begin
      in_ctl_q <= in_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= sample_index_i;
  end

  pcpg_phase #(
    .PHASE_STEPS_PER_TURN(PHASE_STEPS_PER_TURN),
    .FRACTION_BITS       (FRACTION_BITS)
  ) u_phase (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (in_ctl_q),
    .idx_i (idx_q),
    .ctl_o (ph_ctl),
    .ph_o  (ph),
    .phk_o (phk),
    .t_o   (ph_t)
  );

  pcpg_trig #(
    .PHASE_STEPS_PER_TURN(PHASE_STEPS_PER_TURN),
    .FRACTION_BITS       (FRACTION_BITS)
  ) u_trig (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (ph_ctl),
    .ph_i  (ph),
    .phk_i (phk),
    .t_i   (ph_t),
    .ctl_o (trig_ctl),
    .cos_o (cos_v),
    .sin_o (sin_v),
    .cosk_o(cosk_v),
    .sink_o(sink_v),
    .t_o   (trig_t)
  );

  pcpg_shape #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_shape (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (trig_ctl),
    .cos_i  (cos_v),
    .sin_i  (sin_v),
    .cosk_i (cosk_v),
    .sink_i (sink_v),
    .t_i    (trig_t),
    .ctl_o  (shape_ctl),
    .off_x_o(off_x),
    .off_y_o(off_y)
  );

  // Output register: the pixel wraps to its 13 bits like the coordinate sum.
  assign pixel_x_d = $signed(PIXEL_W'(center_x_q)) + off_x;
  assign pixel_y_d = $signed(PIXEL_W'(center_y_q)) + off_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ctl_q <= '0;
    end else begin
      out_ctl_q <= shape_ctl;
    end
  end

  always_ff @(posedge clk_i) begin
    pixel_x_q <= pixel_x_d;
    pixel_y_q <= pixel_y_d;
  end

  assign result_valid_o = out_ctl_q.valid;
  assign beyond_end_o   = out_ctl_q.beyond;
  assign pixel_x_o      = pixel_x_q;
  assign pixel_y_o      = pixel_y_q;

  // Every accepted sample produces exactly one point, a fixed time later.
  `PCPG_ASSERT_IMPLY(a_point_follows_sample, start && !busy, ##LATENCY result_valid_o)
  `PCPG_ASSERT_IMPLY(a_point_has_sample, result_valid_o, $past(start && !busy, LATENCY))
  // Only the cycloid has fewer samples than the index range.
  `PCPG_ASSERT_IMPLY(a_beyond_only_cycloid, result_valid_o && beyond_end_o,
                     out_ctl_q.mode == SHAPE_CYCLOID)
  `PCPG_ASSERT_NEXT(a_center_x_written, cfg_write && (paddr[3:2] == REG_CENTER_X),
                    center_x_q == $past(pwdata[CENTER_W-1:0]))

endmodule

`default_nettype wire

/* design/pcpg_phase.sv */
// Phase stage: sample index to table phases of t and of the curve's angle multiple.
`default_nettype none

module pcpg_phase #(
  parameter int unsigned PHASE_STEPS_PER_TURN = 256,
  parameter int unsigned FRACTION_BITS        = 15
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  pcpg_pkg::ctl_t                          ctl_i,
  input  logic [pcpg_pkg::IDX_W-1:0]              idx_i,
  output pcpg_pkg::ctl_t                          ctl_o,
  output logic [$clog2(PHASE_STEPS_PER_TURN)-1:0] ph_o,
  output logic [$clog2(PHASE_STEPS_PER_TURN)-1:0] phk_o,
  output logic [FRACTION_BITS+5:0]                t_o
);
  import pcpg_pkg::*;

  localparam int unsigned PhW = $clog2(6 * PHASE_STEPS_PER_TURN);
  localparam int unsigned IW  = $clog2(PHASE_STEPS_PER_TURN);
  localparam int unsigned TW  = FRACTION_BITS + 6;

  localparam logic [PhW-1:0] STEP_ASTROID =
    PhW'(TURNS_ASTROID * PHASE_STEPS_PER_TURN / STEPS_ASTROID);
  localparam logic [PhW-1:0] STEP_CYCLOID =
    PhW'(TURNS_CYCLOID * PHASE_STEPS_PER_TURN / STEPS_CYCLOID);
  localparam logic [PhW-1:0] STEP_HUYGENS =
    PhW'(TURNS_HUYGENS * PHASE_STEPS_PER_TURN / STEPS_HUYGENS);
  localparam logic [PhW-1:0] STEP_HYPOCYCLOID =
    PhW'(TURNS_HYPOCYCLOID * PHASE_STEPS_PER_TURN / STEPS_HYPOCYCLOID);

  localparam logic [PhW-1:0] TURN_1 = PhW'(PHASE_STEPS_PER_TURN);
  localparam logic [PhW-1:0] TURN_2 = PhW'(2 * PHASE_STEPS_PER_TURN);
  localparam logic [PhW-1:0] TURN_4 = PhW'(4 * PHASE_STEPS_PER_TURN);

  typedef logic [TW-1:0] ramp_tbl_t [1 << IDX_W];

  // Linear t of the cycloid in fraction format, one entry per sample index.
  function automatic ramp_tbl_t build_ramp();
    ramp_tbl_t   tbl;
    logic [63:0] ang;
    for (int i = 0; i < (1 << IDX_W); i++) begin
      ang    = 64'(i) * 64'(STEP_CYCLOID) * Q30_TWO_PI / PHASE_STEPS_PER_TURN;
      tbl[i] = TW'(ang >> (30 - FRACTION_BITS));
    end
    return tbl;
  endfunction

  localparam ramp_tbl_t RAMP_TABLE = build_ramp();

  // Every phase here stays below six turns, so three conditional
  // subtractions bring it into one turn.
  function automatic logic [IW-1:0] wrap_turn(input logic [PhW-1:0] v);
    logic [PhW-1:0] r;
    r = v;
    if (r >= TURN_4) r = r - TURN_4;
    if (r >= TURN_2) r = r - TURN_2;
    if (r >= TURN_1) r = r - TURN_1;
    return r[IW-1:0];
  endfunction

  logic [PhW-1:0] step;
  logic [PhW-1:0] ph;
  logic [PhW-1:0] phk;

  ctl_t           ctl_q;
  logic [IW-1:0]  ph_q;
  logic [IW-1:0]  phk_q;
  logic [TW-1:0]  t_q;

  always_comb begin
    case (ctl_i.mode)
      SHAPE_ASTROID:     step = STEP_ASTROID;
      SHAPE_CYCLOID:     step = STEP_CYCLOID;
      SHAPE_HUYGENS:     step = STEP_HUYGENS;
      default:           step = STEP_HYPOCYCLOID;
    endcase
    ph = PhW'(idx_i) * step;
    case (ctl_i.mode)
      SHAPE_HUYGENS:     phk = (ph << 1) + ph;
      SHAPE_HYPOCYCLOID: phk = ph << 1;
      default:           phk = ph;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ph_q  <= wrap_turn(ph);
    phk_q <= wrap_turn(phk);
    t_q   <= RAMP_TABLE[idx_i];
  end

  assign ctl_o = ctl_q;
  assign ph_o  = ph_q;
  assign phk_o = phk_q;
  assign t_o   = t_q;

endmodule

`default_nettype wire

/* design/pcpg_trig.sv */
// Trig stage: sine and cosine table lookups for both phases.
`default_nettype none

module pcpg_trig #(
  parameter int unsigned PHASE_STEPS_PER_TURN = 256,
  parameter int unsigned FRACTION_BITS        = 15
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  pcpg_pkg::ctl_t                          ctl_i,
  input  logic [$clog2(PHASE_STEPS_PER_TURN)-1:0] ph_i,
  input  logic [$clog2(PHASE_STEPS_PER_TURN)-1:0] phk_i,
  input  logic [FRACTION_BITS+5:0]                t_i,
  output pcpg_pkg::ctl_t                          ctl_o,
  output logic signed [FRACTION_BITS+1:0]         cos_o,
  output logic signed [FRACTION_BITS+1:0]         sin_o,
  output logic signed [FRACTION_BITS+1:0]         cosk_o,
  output logic signed [FRACTION_BITS+1:0]         sink_o,
  output logic [FRACTION_BITS+5:0]                t_o
);
  import pcpg_pkg::*;

  localparam int unsigned SW = FRACTION_BITS + 2;
  localparam int unsigned TW = FRACTION_BITS + 6;

  typedef logic signed [SW-1:0] trig_tbl_t [PHASE_STEPS_PER_TURN];

  // Sine of a Q30 angle in [0, 2pi): fold to the first quadrant, run a
  // nested Taylor series in Q30, then round half up to the table format.
  function automatic logic signed [SW-1:0] sin_q30(input logic [63:0] ang);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] acc;
    logic [63:0] r;
    logic        neg;
    x   = ang;
    neg = 1'b0;
    if (x >= Q30_PI) begin
      x   = x - Q30_PI;
      neg = 1'b1;
    end
    if (x > Q30_HALF_PI) x = Q30_PI - x;
    x2  = (x * x) >> 30;
    acc = Q30_ONE;
    acc = Q30_ONE - (((x2 * acc) >> 30) / 156);
    acc = Q30_ONE - (((x2 * acc) >> 30) / 110);
    acc = Q30_ONE - (((x2 * acc) >> 30) / 72);
    acc = Q30_ONE - (((x2 * acc) >> 30) / 42);
    acc = Q30_ONE - (((x2 * acc) >> 30) / 20);
    acc = Q30_ONE - (((x2 * acc) >> 30) / 6);
    r   = (x * acc) >> 30;
    r   = (r + (64'd1 << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS);
    return neg ? -$signed(r[SW-1:0]) : $signed(r[SW-1:0]);
  endfunction

  function automatic trig_tbl_t build_sin();
    trig_tbl_t   tbl;
    logic [63:0] ang;
    for (int p = 0; p < PHASE_STEPS_PER_TURN; p++) begin
      ang    = 64'(p) * Q30_TWO_PI / PHASE_STEPS_PER_TURN;
      tbl[p] = sin_q30(ang);
    end
    return tbl;
  endfunction

  // Cosine is the sine of the same angle advanced by a quarter turn.
  function automatic trig_tbl_t build_cos();
    trig_tbl_t   tbl;
    logic [63:0] ang;
    for (int p = 0; p < PHASE_STEPS_PER_TURN; p++) begin
      ang = 64'(p) * Q30_TWO_PI / PHASE_STEPS_PER_TURN + Q30_HALF_PI;
      if (ang >= Q30_TWO_PI) ang = ang - Q30_TWO_PI;
      tbl[p] = sin_q30(ang);
    end
    return tbl;
  endfunction

  localparam trig_tbl_t SIN_TABLE = build_sin();
  localparam trig_tbl_t COS_TABLE = build_cos();

  ctl_t                 ctl_q;
  logic signed [SW-1:0] cos_q;
  logic signed [SW-1:0] sin_q;
  logic signed [SW-1:0] cosk_q;
  logic signed [SW-1:0] sink_q;
  logic [TW-1:0]        t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cos_q  <= COS_TABLE[ph_i];
    sin_q  <= SIN_TABLE[ph_i];
    cosk_q <= COS_TABLE[phk_i];
    sink_q <= SIN_TABLE[phk_i];
    t_q    <= t_i;
  end

  assign ctl_o  = ctl_q;
  assign cos_o  = cos_q;
  assign sin_o  = sin_q;
  assign cosk_o = cosk_q;
  assign sink_o = sink_q;
  assign t_o    = t_q;

endmodule

`default_nettype wire

/* design/pcpg_shape.sv */
// Shape stages: curve formula per mode, cube products and final scaling.
`default_nettype none

module pcpg_shape #(
  parameter int unsigned FRACTION_BITS = 15
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pcpg_pkg::ctl_t                      ctl_i,
  input  logic signed [FRACTION_BITS+1:0]     cos_i,
  input  logic signed [FRACTION_BITS+1:0]     sin_i,
  input  logic signed [FRACTION_BITS+1:0]     cosk_i,
  input  logic signed [FRACTION_BITS+1:0]     sink_i,
  input  logic [FRACTION_BITS+5:0]            t_i,
  output pcpg_pkg::ctl_t                      ctl_o,
  output logic signed [pcpg_pkg::PIXEL_W-1:0] off_x_o,
  output logic signed [pcpg_pkg::PIXEL_W-1:0] off_y_o
);
  import pcpg_pkg::*;

  localparam int unsigned SW = FRACTION_BITS + 2;
  localparam int unsigned VW = FRACTION_BITS + 7;

  localparam logic signed [VW-1:0] ONE_Q = VW'(64'd1 << FRACTION_BITS);

  localparam logic [6:0] SCALE_ASTROID     = 7'd80;
  localparam logic [6:0] SCALE_CYCLOID     = 7'd6;
  localparam logic [6:0] SCALE_HUYGENS     = 7'd16;
  localparam logic [6:0] SCALE_HYPOCYCLOID = 7'd45;

  // Product of two fraction values, magnitude truncated toward zero.
  function automatic logic signed [SW-1:0] mul_q(input logic signed [SW-1:0] a,
                                                 input logic signed [SW-1:0] b);
    logic [SW-1:0]   am;
    logic [SW-1:0]   bm;
    logic [2*SW-1:0] p;
    logic [SW-1:0]   m;
    am = a[SW-1] ? $unsigned(-a) : $unsigned(a);
    bm = b[SW-1] ? $unsigned(-b) : $unsigned(b);
    p  = (2*SW)'(am) * (2*SW)'(bm);
    m  = SW'(p >> FRACTION_BITS);
    return (a[SW-1] != b[SW-1]) ? -$signed(m) : $signed(m);
  endfunction

  // Scale to pixels and truncate toward zero; halve covers the 45/2 scale.
  function automatic logic signed [PIXEL_W-1:0] scale_trunc(input logic signed [VW-1:0] v,
                                                            input logic [6:0] num,
                                                            input logic halve);
    logic [VW-1:0]      vm;
    logic [VW+6:0]      p;
    logic [VW+6:0]      q;
    logic [PIXEL_W-1:0] m;
    vm = v[VW-1] ? $unsigned(-v) : $unsigned(v);
    p  = (VW+7)'(vm) * (VW+7)'(num);
    q  = halve ? (p >> (FRACTION_BITS + 1)) : (p >> FRACTION_BITS);
    m  = q[PIXEL_W-1:0];
    return v[VW-1] ? -$signed(m) : $signed(m);
  endfunction

  logic signed [VW-1:0] cx;
  logic signed [VW-1:0] sx;
  logic signed [VW-1:0] ckx;
  logic signed [VW-1:0] skx;
  logic signed [VW-1:0] ax_d;
  logic signed [VW-1:0] ay_d;
  logic signed [VW-1:0] vx_d;
  logic signed [VW-1:0] vy_d;
  logic [6:0]           num;
  logic                 halve;

  ctl_t                      ctl3_q;
  logic signed [VW-1:0]      ax_q;
  logic signed [VW-1:0]      ay_q;
  logic signed [SW-1:0]      fx_q;
  logic signed [SW-1:0]      fy_q;
  ctl_t                      ctl4_q;
  logic signed [VW-1:0]      vx_q;
  logic signed [VW-1:0]      vy_q;
  ctl_t                      ctl5_q;
  logic signed [PIXEL_W-1:0] off_x_q;
  logic signed [PIXEL_W-1:0] off_y_q;

  // First stage: the astroid starts its cubes, the Huygens curve and the hypocycloid form
  // their linear combination of the two angle multiples, the cycloid its 1 - cos and t - sin.
  always_comb begin
    cx  = VW'(cos_i);
    sx  = VW'(sin_i);
    ckx = VW'(cosk_i);
    skx = VW'(sink_i);
    case (ctl_i.mode)
      SHAPE_ASTROID: begin
        ax_d = VW'(mul_q(cos_i, cos_i));
        ay_d = VW'(mul_q(sin_i, sin_i));
      end
      SHAPE_CYCLOID: begin
        ax_d = ONE_Q - cx;
        ay_d = $signed(VW'(t_i)) - sx;
      end
      SHAPE_HUYGENS: begin
        ax_d = (cx <<< 1) + cx - ckx;
        ay_d = (sx <<< 1) + sx - skx;
      end
      default: begin
        ax_d = (cx <<< 1) + ckx;
        ay_d = (sx <<< 1) - skx;
      end
    endcase
  end

  always_comb begin
    if (ctl3_q.mode == SHAPE_ASTROID) begin
      vx_d = VW'(mul_q(SW'(ax_q), fx_q));
      vy_d = VW'(mul_q(SW'(ay_q), fy_q));
    end else begin
      vx_d = ax_q;
      vy_d = ay_q;
    end
  end

  always_comb begin
    halve = 1'b0;
    case (ctl4_q.mode)
      SHAPE_ASTROID: num = SCALE_ASTROID;
      SHAPE_CYCLOID: num = SCALE_CYCLOID;
      SHAPE_HUYGENS: num = SCALE_HUYGENS;
      default: begin
        num   = SCALE_HYPOCYCLOID;
        halve = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl3_q <= '0;
      ctl4_q <= '0;
      ctl5_q <= '0;
    end else begin
      ctl3_q <= ctl_i;
      ctl4_q <= ctl3_q;
      ctl5_q <= ctl4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q    <= ax_d;
    ay_q    <= ay_d;
    fx_q    <= cos_i;
    fy_q    <= sin_i;
    vx_q    <= vx_d;
    vy_q    <= vy_d;
    off_x_q <= scale_trunc(vx_q, num, halve);
    off_y_q <= scale_trunc(vy_q, num, halve);
  end

  assign ctl_o   = ctl5_q;
  assign off_x_o = off_x_q;
  assign off_y_o = off_y_q;

endmodule

`default_nettype wire
